FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file rfm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define RFM_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset
`define RFM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/rfm_pkg.sv
`default_nettype none

package rfm_pkg;

    // Register map, index of each configuration register
    localparam logic [1:0] REG_DIAMETER   = 2'd0;
    localparam logic [1:0] REG_FADE_BEGIN = 2'd1;
    localparam logic [1:0] REG_FADE_END   = 2'd2;

    localparam int ADDR_W    = 4;
    localparam int DIAM_W    = 9;
    localparam int BOUND_W   = 16;
    localparam int PIX_W     = 8;
    localparam int WEIGHT_W  = 16;

    localparam logic [DIAM_W-1:0]   DIAMETER_RST   = 9'd256;
    localparam logic [BOUND_W-1:0]  FADE_BEGIN_RST = 16'd14746;
    localparam logic [BOUND_W-1:0]  FADE_END_RST   = 16'd16384;
    localparam logic [WEIGHT_W-1:0] ONE_Q15        = 16'd32768;

    // Square root datapath: radicand S << 30, padded to an even width
    localparam int SQ_STEPS = 25;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SQREM_W  = ROOT_W + 2;
    localparam int SUMSQ_W  = 19;
    localparam int FRAC_SH  = 30;

    // Ratio divider (root / diameter) and weight divider
    localparam int DIV1_REM_W = DIAM_W + 1;
    localparam int DIV2_REM_W = BOUND_W + 2;

endpackage

`default_nettype wire

FILE: hw/rtl/rfm_sqrt_cell.sv
`default_nettype none

module rfm_sqrt_cell
    import rfm_pkg::*;
#(
    parameter int CELL_RAD_W  = RAD_W,
    parameter int CELL_ROOT_W = ROOT_W,
    parameter int CELL_REM_W  = SQREM_W,
    parameter int SB_W        = 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [CELL_RAD_W-1:0]  in_rad,
    input  wire logic [CELL_REM_W-1:0]  in_rem,
    input  wire logic [CELL_ROOT_W-1:0] in_root,
    input  wire logic [SB_W-1:0]        in_sb,
    output logic                        out_valid,
    output logic [CELL_RAD_W-1:0]       out_rad,
    output logic [CELL_REM_W-1:0]       out_rem,
    output logic [CELL_ROOT_W-1:0]      out_root,
    output logic [SB_W-1:0]             out_sb
);

    logic [CELL_REM_W-1:0] rem_sh;
    logic [CELL_REM_W-1:0] trial;
    logic                  fits;

    // Bring down the next two radicand bits and test one root bit
    always_comb begin
        rem_sh = {in_rem[CELL_REM_W-3:0], in_rad[CELL_RAD_W-1 -: 2]};
        trial  = {in_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    // Advance the partial root and remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            out_rad  <= {in_rad[CELL_RAD_W-3:0], 2'b00};
            out_rem  <= fits ? (rem_sh - trial) : rem_sh;
            out_root <= {in_root[CELL_ROOT_W-2:0], fits};
            out_sb   <= in_sb;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rfm_div_cell.sv
`default_nettype none

module rfm_div_cell
    import rfm_pkg::*;
#(
    parameter int REM_W = DIV1_REM_W,
    parameter int NUM_W = ROOT_W,
    parameter int SB_W  = 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic [REM_W-2:0]   divisor,
    input  wire logic               in_valid,
    input  wire logic [REM_W-2:0]   in_rem,
    input  wire logic [NUM_W-1:0]   in_num,
    input  wire logic [SB_W-1:0]    in_sb,
    output logic                    out_valid,
    output logic [REM_W-2:0]        out_rem,
    output logic [NUM_W-1:0]        out_num,
    output logic [SB_W-1:0]         out_sb
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] rem_sub;
    logic             fits;

    // Shift in one dividend bit and try a subtract
    always_comb begin
        rem_sh  = {in_rem, in_num[NUM_W-1]};
        fits    = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    // Quotient bits fill the dividend register from the bottom
    always_ff @(posedge aclk) begin
        if (en) begin
            out_rem <= fits ? rem_sub[REM_W-2:0] : rem_sh[REM_W-2:0];
            out_num <= {in_num[NUM_W-2:0], fits};
            out_sb  <= in_sb;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/radial_fade_mask_generator.sv
// Pipeline from input transfer to result: 1 input stage, 25 square-root cells,
// 25 ratio divider cells, 1 compare stage, 16 weight divider cells, 1 output.
// Throughput: one pixel per cycle; the whole cell chain advances together and holds
// when the output register is full and not taken.
// Reset (aresetn, synchronous, active low): pipeline valid bits clear, registers
// return to diameter 256, fade_begin 14746, fade_end 16384.
`default_nettype none

module radial_fade_mask_generator
    import rfm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // Pixel input
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [PIX_W-1:0]    s_pixel_row,
    input  wire logic [PIX_W-1:0]    s_pixel_col,
    // Weight output
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [WEIGHT_W-1:0]      m_weight
);

    logic [DIAM_W-1:0]  diameter_reg;
    logic [BOUND_W-1:0] fade_begin_reg;
    logic [BOUND_W-1:0] fade_end_reg;
    logic               en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diameter_reg   <= DIAMETER_RST;
            fade_begin_reg <= FADE_BEGIN_RST;
            fade_end_reg   <= FADE_END_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_DIAMETER:   diameter_reg   <= pwdata[DIAM_W-1:0];
                REG_FADE_BEGIN: fade_begin_reg <= pwdata[BOUND_W-1:0];
                REG_FADE_END:   fade_end_reg   <= pwdata[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_DIAMETER:   prdata = {{(32-DIAM_W){1'b0}}, diameter_reg};
            REG_FADE_BEGIN: prdata = {{(32-BOUND_W){1'b0}}, fade_begin_reg};
            REG_FADE_END:   prdata = {{(32-BOUND_W){1'b0}}, fade_end_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // Whole chain moves unless the output holds an untaken result
    logic m_valid_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // Input stage: distances from center and sum of squares
    logic [DIAM_W-1:0]   two_row, two_col, dx, dy;
    logic [2*DIAM_W-1:0] dx_sq, dy_sq;
    logic [SUMSQ_W-1:0]  sumsq;
    always_comb begin
        two_row = {s_pixel_row, 1'b0};
        two_col = {s_pixel_col, 1'b0};
        dx = (diameter_reg >= two_row) ? diameter_reg - two_row : two_row - diameter_reg;
        dy = (diameter_reg >= two_col) ? diameter_reg - two_col : two_col - diameter_reg;
        dx_sq = dx * dx;
        dy_sq = dy * dy;
        sumsq = SUMSQ_W'(dx_sq) + SUMSQ_W'(dy_sq);
    end

    logic               in0_valid_reg;
    logic [RAD_W-1:0]   in0_rad_reg;
    logic               in0_zd_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in0_valid_reg <= 1'b0;
        end else if (en) begin
            in0_valid_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            in0_rad_reg <= {{(RAD_W-SUMSQ_W-FRAC_SH){1'b0}}, sumsq, {FRAC_SH{1'b0}}};
            in0_zd_reg  <= (diameter_reg == '0);
        end
    end

    // Square root cells, one root bit each
    logic               sq_valid [0:SQ_STEPS];
    logic [RAD_W-1:0]   sq_rad   [0:SQ_STEPS];
    logic [SQREM_W-1:0] sq_rem   [0:SQ_STEPS];
    logic [ROOT_W-1:0]  sq_root  [0:SQ_STEPS];
    logic               sq_zd    [0:SQ_STEPS];

    assign sq_valid[0] = in0_valid_reg;
    assign sq_rad[0]   = in0_rad_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_zd[0]    = in0_zd_reg;

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        rfm_sqrt_cell #(
            .CELL_RAD_W  (RAD_W),
            .CELL_ROOT_W (ROOT_W),
            .CELL_REM_W  (SQREM_W),
            .SB_W        (1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_rad    (sq_rad[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_sb     (sq_zd[i]),
            .out_valid (sq_valid[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_sb    (sq_zd[i+1])
        );
    end

    // Ratio divider cells: root / diameter
    logic                  d1_valid [0:ROOT_W];
    logic [DIAM_W-1:0]     d1_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]     d1_num   [0:ROOT_W];
    logic                  d1_zd    [0:ROOT_W];

    assign d1_valid[0] = sq_valid[SQ_STEPS];
    assign d1_rem[0]   = '0;
    assign d1_num[0]   = sq_root[SQ_STEPS];
    assign d1_zd[0]    = sq_zd[SQ_STEPS];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_div1
        rfm_div_cell #(
            .REM_W (DIV1_REM_W),
            .NUM_W (ROOT_W),
            .SB_W  (1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .divisor   (diameter_reg),
            .in_valid  (d1_valid[i]),
            .in_rem    (d1_rem[i]),
            .in_num    (d1_num[i]),
            .in_sb     (d1_zd[i]),
            .out_valid (d1_valid[i+1]),
            .out_rem   (d1_rem[i+1]),
            .out_num   (d1_num[i+1]),
            .out_sb    (d1_zd[i+1])
        );
    end

    // Compare stage: round ratio, pick forced weight or set up the fade divide
    logic [ROOT_W:0]    t_inc;
    logic [ROOT_W-1:0]  ratio;
    logic [BOUND_W-1:0] span;
    logic               ratio_low, ratio_high;
    always_comb begin
        t_inc      = {1'b0, d1_num[ROOT_W]} + (ROOT_W+1)'(1);
        ratio      = t_inc[ROOT_W:1];
        span       = fade_end_reg - fade_begin_reg;
        ratio_low  = (ratio <= ROOT_W'(fade_begin_reg));
        ratio_high = (ratio >= ROOT_W'(fade_end_reg));
    end

    logic                cmp_valid_reg;
    logic                cmp_force_reg;
    logic [WEIGHT_W-1:0] cmp_fw_reg;
    logic [BOUND_W-1:0]  cmp_num_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else if (en) begin
            cmp_valid_reg <= d1_valid[ROOT_W];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            cmp_force_reg <= d1_zd[ROOT_W] || ratio_low || ratio_high;
            cmp_fw_reg    <= (!d1_zd[ROOT_W] && ratio_low) ? ONE_Q15 : '0;
            cmp_num_reg   <= fade_end_reg - ratio[BOUND_W-1:0];
        end
    end

    // Weight divider cells: (65536*num + span) / (2*span)
    localparam int D2_SB_W = WEIGHT_W + 1;
    logic                      d2_valid [0:BOUND_W];
    logic [BOUND_W:0]          d2_rem   [0:BOUND_W];
    logic [BOUND_W-1:0]        d2_num   [0:BOUND_W];
    logic [D2_SB_W-1:0]        d2_sb    [0:BOUND_W];
    logic [BOUND_W:0]          span2;

    assign span2       = {span, 1'b0};
    assign d2_valid[0] = cmp_valid_reg;
    assign d2_rem[0]   = {1'b0, cmp_num_reg};
    assign d2_num[0]   = span;
    assign d2_sb[0]    = {cmp_force_reg, cmp_fw_reg};

    for (genvar i = 0; i < BOUND_W; i++) begin : g_div2
        rfm_div_cell #(
            .REM_W (DIV2_REM_W),
            .NUM_W (BOUND_W),
            .SB_W  (D2_SB_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .divisor   (span2),
            .in_valid  (d2_valid[i]),
            .in_rem    (d2_rem[i]),
            .in_num    (d2_num[i]),
            .in_sb     (d2_sb[i]),
            .out_valid (d2_valid[i+1]),
            .out_rem   (d2_rem[i+1]),
            .out_num   (d2_num[i+1]),
            .out_sb    (d2_sb[i+1])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_valid[BOUND_W];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            weight_reg <= d2_sb[BOUND_W][WEIGHT_W] ? d2_sb[BOUND_W][WEIGHT_W-1:0]
                                                   : d2_num[BOUND_W];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_weight = weight_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rfm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rfm_checker
    import rfm_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                pready,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [WEIGHT_W-1:0] m_weight
);

    // A stalled result holds its value
    `RFM_ASSERT_CLK(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_weight)))

    // Weight never exceeds one
    `RFM_ASSERT_CLK(a_weight_range, aclk, aresetn, m_valid |-> (m_weight <= ONE_Q15))

    // Empty output never blocks the input
    `RFM_ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready)

    // Configuration port never waits
    `RFM_ASSERT_ALWAYS(a_pready_high, aclk, pready)

endmodule

bind radial_fade_mask_generator rfm_checker u_rfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_weight (m_weight)
);

`default_nettype wire
